// File: hdl/cca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_pkg: shared types and constants for the cave automaton block
// Command codes, word layouts, register indexes and reset values.
// ----------------------------------------------------------------------------
package cca_pkg;

	// Default grid capacity
	localparam int CCA_MAX_COLS = 128;
	localparam int CCA_MAX_ROWS = 32;

	// Configuration port
	localparam int CCA_CFG_IDX_W  = 2;
	localparam int CCA_CFG_DATA_W = 8;

	// Register reset values
	localparam logic [7:0] CCA_WIDTH_RST   = 8'd80;
	localparam logic [5:0] CCA_HEIGHT_RST  = 6'd25;
	localparam logic [3:0] CCA_SURVIVE_RST = 4'd4;
	localparam logic [3:0] CCA_BIRTH_RST   = 4'd3;

	// Register indexes
	typedef enum logic [CCA_CFG_IDX_W-1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_SURVIVE_MIN = 2'd2,
		REG_BIRTH_MIN   = 2'd3
	} reg_idx_t;

	// Command codes
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_GEN   = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_GEN  = 2'd2
	} state_t;

	// Input word
	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] col;
		logic [4:0] row;
		logic       wall_in;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic wall_out;
		logic coord_error;
	} out_word_t;

	// Neighbor qualifiers for the cell under update
	typedef struct packed {
		logic in_use;
		logic up;
		logic down;
		logic left;
		logic right;
	} nb_mask_t;

endpackage

// File: hdl/cca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cca_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/cca_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cca_window: raster neighborhood window and cell rule
// Shift line of two rows plus three cells; counts the walls around the
// center tap and applies the survive / birth thresholds.
// ----------------------------------------------------------------------------
module cca_window import cca_pkg::*; #(
	parameter int MAX_COLS = CCA_MAX_COLS
) (
	input  logic       clk,
	input  logic       shift_en,
	input  logic       din,
	input  nb_mask_t   mask,
	input  logic [3:0] survive_min,
	input  logic [3:0] birth_min,
	output logic       new_cell
);

	localparam int TAPS = 2 * MAX_COLS + 3;

	logic [TAPS-1:0] sr_q;
	logic            c_up_l, c_up, c_up_r, c_left, c_center, c_right;
	logic            c_dn_l, c_dn, c_dn_r;
	logic [3:0]      count;
	logic [3:0]      thresh;

	// Advance the raster line, newest cell at tap 0
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sr_q <= {sr_q[TAPS-2:0], din};
		end
	end

	// Pick the neighborhood taps and drop neighbors off the grid in use
	assign c_center = sr_q[MAX_COLS+1];
	assign c_up_l   = sr_q[2*MAX_COLS+2] & mask.up & mask.left;
	assign c_up     = sr_q[2*MAX_COLS+1] & mask.up;
	assign c_up_r   = sr_q[2*MAX_COLS]   & mask.up & mask.right;
	assign c_left   = sr_q[MAX_COLS+2]   & mask.left;
	assign c_right  = sr_q[MAX_COLS]     & mask.right;
	assign c_dn_l   = sr_q[2]            & mask.down & mask.left;
	assign c_dn     = sr_q[1]            & mask.down;
	assign c_dn_r   = sr_q[0]            & mask.down & mask.right;

	// Count walls and apply the rule; cells outside the grid in use hold
	always_comb begin
		count = 4'(c_up_l) + 4'(c_up) + 4'(c_up_r) + 4'(c_left)
		      + 4'(c_right) + 4'(c_dn_l) + 4'(c_dn) + 4'(c_dn_r);
		thresh   = c_center ? survive_min : birth_min;
		new_cell = mask.in_use ? (count >= thresh) : c_center;
	end

endmodule

// File: hdl/cave_cellular_automaton_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cave_cellular_automaton_step: cave generation cellular automaton
// Two grid banks; write cell, read cell, or run one generation into the
// other bank and swap.
// ----------------------------------------------------------------------------
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+---------------------------
// command  | start, busy, req (in_word_t)           | start && !busy
// result   | done, rsp (out_word_t)                 | done, one cycle, no stall
// config   | cfg_valid, cfg_ready, cfg_index,       | cfg_valid && cfg_ready
//          | cfg_data                               |
//
// Write: busy stays low, result strobes on the next cycle.
// Read: busy in ST_READ while the registered bank RAM read completes, then
// the result word is registered.
// Generation: busy in ST_GEN while the bank RAM read port streams one cell
// per cycle in raster order and the count unit settles one cell per cycle,
// then result strobes.
// Reset sets register reset values, clears bank select; grid is unknown.
// ----------------------------------------------------------------------------
module cave_cellular_automaton_step import cca_pkg::*; #(
	parameter int MAX_COLS = CCA_MAX_COLS,
	parameter int MAX_ROWS = CCA_MAX_ROWS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  in_word_t                  req,
	output logic                      done,
	output out_word_t                 rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CCA_CFG_IDX_W-1:0]  cfg_index,
	input  logic [CCA_CFG_DATA_W-1:0] cfg_data
);

	localparam int N     = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(N);
	localparam int CCW   = $clog2(MAX_COLS);
	localparam int RRW   = $clog2(MAX_ROWS);
	localparam int LAST  = N + MAX_COLS + 2;
	localparam int SW    = $clog2(LAST + 1);
	localparam int EMIT0 = MAX_COLS + 3;
	localparam int UCW   = $clog2(MAX_COLS + 1);
	localparam int URW   = $clog2(MAX_ROWS + 1);
	localparam int CMPW  = (UCW > 8) ? UCW : 8;
	localparam int RMPW  = (URW > 6) ? URW : 6;

	// Configuration and control registers
	logic [7:0]     width_q;
	logic [5:0]     height_q;
	logic [3:0]     survive_q;
	logic [3:0]     birth_q;
	state_t         state_q, state_d;
	logic           active_q;
	logic [SW-1:0]  step_q;
	logic [AW-1:0]  waddr_q;
	logic [CCW-1:0] ccol_q;
	logic [RRW-1:0] crow_q;
	logic           done_q;
	out_word_t      rsp_q;

	// Combinational controls
	logic            accept;
	logic            coord_ok;
	logic [CMPW-1:0] used_cols, gw_ext;
	logic [RMPW-1:0] used_rows, gh_ext;
	logic [AW-1:0]   cmd_addr;
	logic [AW-1:0]   raddr, waddr;
	logic            we, wbank, wdata;
	logic            rdata_a, rdata_b, rdata_cur;
	logic            done_d;
	out_word_t       rsp_d;
	logic            gen_start, gen_emit, gen_last;
	nb_mask_t        mask;
	logic            new_cell;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// Clamp the size in use to the grid capacity
	always_comb begin
		gw_ext    = CMPW'(width_q);
		gh_ext    = RMPW'(height_q);
		used_cols = (gw_ext > CMPW'(MAX_COLS)) ? CMPW'(MAX_COLS) : gw_ext;
		used_rows = (gh_ext > RMPW'(MAX_ROWS)) ? RMPW'(MAX_ROWS) : gh_ext;
		coord_ok  = (CMPW'(req.col) < used_cols) && (RMPW'(req.row) < used_rows);
		cmd_addr  = AW'(32'(req.row) * MAX_COLS + 32'(req.col));
	end

	// Qualify neighbors of the cell under update
	always_comb begin
		mask.in_use = (CMPW'(ccol_q) < used_cols) && (RMPW'(crow_q) < used_rows);
		mask.left   = (ccol_q != '0);
		mask.right  = ((CMPW'(ccol_q) + CMPW'(1)) < used_cols);
		mask.up     = (crow_q != '0);
		mask.down   = ((RMPW'(crow_q) + RMPW'(1)) < used_rows);
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= CCA_WIDTH_RST;
			height_q  <= CCA_HEIGHT_RST;
			survive_q <= CCA_SURVIVE_RST;
			birth_q   <= CCA_BIRTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GRID_WIDTH:  width_q   <= cfg_data;
				REG_GRID_HEIGHT: height_q  <= cfg_data[5:0];
				REG_SURVIVE_MIN: survive_q <= cfg_data[3:0];
				REG_BIRTH_MIN:   birth_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, bank port controls and result word
	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		wbank     = active_q;
		waddr     = cmd_addr;
		wdata     = req.wall_in;
		raddr     = cmd_addr;
		done_d    = 1'b0;
		rsp_d     = '0;
		gen_start = 1'b0;
		gen_emit  = 1'b0;
		gen_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(req.cmd))
						CMD_WRITE: begin
							we                = coord_ok;
							done_d            = 1'b1;
							rsp_d.coord_error = !coord_ok;
						end
						CMD_GEN: begin
							gen_start = 1'b1;
							state_d   = ST_GEN;
						end
						CMD_READ: begin
							if (coord_ok) begin
								state_d = ST_READ;
							end else begin
								done_d            = 1'b1;
								rsp_d.coord_error = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				done_d         = 1'b1;
				rsp_d.wall_out = rdata_cur;
				state_d        = ST_IDLE;
			end
			ST_GEN: begin
				raddr = (step_q < SW'(N)) ? AW'(step_q) : '0;
				if (step_q >= SW'(EMIT0)) begin
					gen_emit = 1'b1;
					we       = 1'b1;
					wbank    = !active_q;
					waddr    = waddr_q;
					wdata    = new_cell;
				end
				if (step_q == SW'(LAST)) begin
					gen_last = 1'b1;
					done_d   = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the generation counters and swap banks at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
			waddr_q  <= '0;
			ccol_q   <= '0;
			crow_q   <= '0;
		end else begin
			if (gen_start) begin
				step_q  <= '0;
				waddr_q <= '0;
				ccol_q  <= '0;
				crow_q  <= '0;
			end else if (state_q == ST_GEN) begin
				step_q <= step_q + SW'(1);
				if (gen_emit) begin
					waddr_q <= waddr_q + AW'(1);
					if (ccol_q == CCW'(MAX_COLS - 1)) begin
						ccol_q <= '0;
						crow_q <= crow_q + RRW'(1);
					end else begin
						ccol_q <= ccol_q + CCW'(1);
					end
				end
			end
			if (gen_last) begin
				active_q <= !active_q;
			end
		end
	end

	// Register the result word and the done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			rsp_q  <= '0;
		end else begin
			done_q <= done_d;
			rsp_q  <= rsp_d;
		end
	end

	// Grid banks
	cca_ram #(
		.WIDTH (1),
		.DEPTH (N)
	) u_bank_a (
		.clk   (clk),
		.we    (we && !wbank),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_a)
	);

	cca_ram #(
		.WIDTH (1),
		.DEPTH (N)
	) u_bank_b (
		.clk   (clk),
		.we    (we && wbank),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_b)
	);

	assign rdata_cur = active_q ? rdata_b : rdata_a;

	// Neighborhood window and rule
	cca_window #(
		.MAX_COLS (MAX_COLS)
	) u_window (
		.clk         (clk),
		.shift_en    (state_q == ST_GEN),
		.din         (rdata_cur),
		.mask        (mask),
		.survive_min (survive_q),
		.birth_min   (birth_q),
		.new_cell    (new_cell)
	);

endmodule

// File: test/cave_step_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cave_step_monitor: result predictor and comparator for the cave automaton
// Mirrors the register file and both grid banks, predicts the result word of
// every accepted command word and compares each strobed result with the
// oldest prediction in order.
// ----------------------------------------------------------------------------
module cave_step_monitor import cca_pkg::*; #(
	parameter int MAX_COLS = CCA_MAX_COLS,
	parameter int MAX_ROWS = CCA_MAX_ROWS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  in_word_t                  req,
	input  logic                      done,
	input  out_word_t                 rsp,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CCA_CFG_IDX_W-1:0]  cfg_index,
	input  logic [CCA_CFG_DATA_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        words_pending
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;

	// Mirrored registers and grid banks
	logic [7:0] width_reg;
	logic [5:0] height_reg;
	logic [3:0] survive_reg;
	logic [3:0] birth_reg;
	bit         grid_mem [2][CELLS];
	bit         live_bank;

	out_word_t  predicted_words[$];
	out_word_t  oldest_word;
	int         fails;

	function automatic int used_cols();
		return (int'(width_reg) > MAX_COLS) ? MAX_COLS : int'(width_reg);
	endfunction

	function automatic int used_rows();
		return (int'(height_reg) > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
	endfunction

	// Count walls around (c, r); neighbors off the grid in use are open
	function automatic int wall_neighbors(int c, int r, int w, int h);
		int n;
		n = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				if ((dr != 0 || dc != 0) && c + dc >= 0 && r + dr >= 0 &&
						c + dc < w && r + dr < h) begin
					n += grid_mem[live_bank][(r + dr) * MAX_COLS + c + dc];
				end
			end
		end
		return n;
	endfunction

	// Build the next generation in the idle bank, copy cells outside the
	// size in use, then swap banks
	function automatic void advance_generation();
		int  w;
		int  h;
		int  n;
		int  idx;
		bit  old;
		w = used_cols();
		h = used_rows();
		for (int r = 0; r < MAX_ROWS; r++) begin
			for (int c = 0; c < MAX_COLS; c++) begin
				idx = r * MAX_COLS + c;
				old = grid_mem[live_bank][idx];
				if (r < h && c < w) begin
					n = wall_neighbors(c, r, w, h);
					grid_mem[!live_bank][idx] = old ? (n >= int'(survive_reg))
						: (n >= int'(birth_reg));
				end else begin
					grid_mem[!live_bank][idx] = old;
				end
			end
		end
		live_bank = !live_bank;
	endfunction

	// Apply one command word and return the result word it produces
	function automatic out_word_t predict_cell_op(in_word_t w);
		out_word_t res;
		bit        in_range;
		int        idx;
		res = '0;
		in_range = int'(w.col) < used_cols() && int'(w.row) < used_rows();
		idx = int'(w.row) * MAX_COLS + int'(w.col);
		case (w.cmd)
			CMD_WRITE: begin
				if (!in_range) res.coord_error = 1'b1;
				else grid_mem[live_bank][idx] = w.wall_in;
			end
			CMD_READ: begin
				if (!in_range) res.coord_error = 1'b1;
				else res.wall_out = grid_mem[live_bank][idx];
			end
			CMD_GEN: begin
				advance_generation();
			end
			default: begin
				// unknown command: nothing changes, both fields stay low
			end
		endcase
		return res;
	endfunction

	// Track config writes, queue predictions, compare results in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg   = CCA_WIDTH_RST;
			height_reg  = CCA_HEIGHT_RST;
			survive_reg = CCA_SURVIVE_RST;
			birth_reg   = CCA_BIRTH_RST;
			live_bank   = 1'b0;
			predicted_words.delete();
			fails = 0;
			fail_count    <= 0;
			words_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_GRID_WIDTH:  width_reg   = cfg_data[7:0];
					REG_GRID_HEIGHT: height_reg  = cfg_data[5:0];
					REG_SURVIVE_MIN: survive_reg = cfg_data[3:0];
					REG_BIRTH_MIN:   birth_reg   = cfg_data[3:0];
					default: ;
				endcase
			end
			if (start && !busy)
				predicted_words.push_back(predict_cell_op(req));
			if (done) begin
				if (predicted_words.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%t ERROR: result word with none outstanding: wall_out=%b coord_error=%b",
							$time, rsp.wall_out, rsp.coord_error);
				end else begin
					oldest_word = predicted_words.pop_front();
					if (rsp.wall_out !== oldest_word.wall_out ||
							rsp.coord_error !== oldest_word.coord_error) begin
						fails++;
						if (fails <= 10)
							$display("%t ERROR: result mismatch: wall_out exp %b got %b, coord_error exp %b got %b",
								$time, oldest_word.wall_out, rsp.wall_out,
								oldest_word.coord_error, rsp.coord_error);
					end
				end
			end
			fail_count    <= fails;
			words_pending <= predicted_words.size();
		end
	end

endmodule

// File: test/tb_cave_cellular_automaton_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cave_cellular_automaton_step: stimulus and verdict for the cave automaton
// Drives directed and random write, read and generation commands over many
// grid sizes and thresholds; a side monitor predicts and checks every word.
// ----------------------------------------------------------------------------
module tb_cave_cellular_automaton_step;
	import cca_pkg::*;

	localparam int         CELLS       = CCA_MAX_COLS * CCA_MAX_ROWS;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      start     = 1'b0;
	in_word_t                  req       = '0;
	logic                      cfg_valid = 1'b0;
	logic [CCA_CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CCA_CFG_DATA_W-1:0] cfg_data  = '0;
	logic                      busy;
	logic                      done;
	logic                      cfg_ready;
	out_word_t                 rsp;
	int                        fail_count;
	int                        words_pending;

	// Which cells of the current grid hold a written value
	bit cell_known [CELLS];
	int used_w;
	int used_h;
	bit steady;
	int n_write, n_read, n_gen, n_coord_err, n_unknown, n_settings;

	cave_cellular_automaton_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cave_step_monitor u_step_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold off the next word for a random gap: mostly none, some short, few long
	task automatic idle_gap();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		len = (steady || pick < 60) ? 0 : (pick < 90) ? $urandom_range(1, 3)
			: $urandom_range(12, 40);
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	// Present one command word and hold it until accepted; start stays high
	task automatic issue(logic [1:0] cmd, int col, int row, bit wall);
		in_word_t w;
		bit       in_range;
		w.cmd = cmd;
		w.col = 7'(col);
		w.row = 5'(row);
		w.wall_in = wall;
		in_range = col < used_w && row < used_h;
		case (cmd)
			CMD_WRITE: begin
				n_write++;
				if (in_range) cell_known[row * CCA_MAX_COLS + col] = 1'b1;
				else n_coord_err++;
			end
			CMD_READ: begin
				n_read++;
				if (!in_range) n_coord_err++;
			end
			CMD_GEN: n_gen++;
			default: n_unknown++;
		endcase
		idle_gap();
		start <= 1'b1;
		req   <= w;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every result word has come back
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write all four registers while idle and track the size in force
	task automatic apply_setting(logic [7:0] w, logic [7:0] hd, logic [7:0] s,
			logic [7:0] b);
		settle();
		write_reg(REG_GRID_WIDTH, w);
		write_reg(REG_GRID_HEIGHT, hd);
		write_reg(REG_SURVIVE_MIN, s);
		write_reg(REG_BIRTH_MIN, b);
		cfg_valid <= 1'b0;
		used_w = (int'(w) > CCA_MAX_COLS) ? CCA_MAX_COLS : int'(w);
		used_h = (int'(hd[5:0]) > CCA_MAX_ROWS) ? CCA_MAX_ROWS : int'(hd[5:0]);
		n_settings++;
	endtask

	// Write every unwritten cell in use so generations and reads stay defined
	task automatic fill_grid();
		int density;
		density = $urandom_range(25, 75);
		for (int r = 0; r < used_h; r++)
			for (int c = 0; c < used_w; c++)
				if (!cell_known[r * CCA_MAX_COLS + c])
					issue(CMD_WRITE, c, r, $urandom_range(0, 99) < density);
	endtask

	task automatic random_items(int count);
		int  pick;
		bit  sized;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			sized = used_w > 0 && used_h > 0;
			if (pick < 30 && sized)
				issue(CMD_WRITE, $urandom_range(0, used_w - 1),
					$urandom_range(0, used_h - 1), 1'($urandom_range(0, 1)));
			else if (pick < 60 && sized)
				issue(CMD_READ, $urandom_range(0, used_w - 1),
					$urandom_range(0, used_h - 1), 1'($urandom_range(0, 1)));
			else if (pick < 70)
				issue(CMD_GEN, $urandom_range(0, 127), $urandom_range(0, 31),
					1'($urandom_range(0, 1)));
			else if (pick < 76)
				issue(CMD_UNKNOWN, $urandom_range(0, 127), $urandom_range(0, 31),
					1'($urandom_range(0, 1)));
			else
				issue($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
					$urandom_range(0, 127), $urandom_range(0, 31),
					1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(logic [7:0] w, logic [7:0] hd, logic [7:0] s,
			logic [7:0] b, int count);
		apply_setting(w, hd, s, b);
		steady = ($urandom_range(0, 3) == 0);
		fill_grid();
		random_items(count);
	endtask

	// Stimulus
	initial begin
		used_w = int'(CCA_WIDTH_RST);
		used_h = int'(CCA_HEIGHT_RST);
		steady = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset size: corner cells, edges of the size in use, unknown command
		issue(CMD_WRITE, 0, 0, 1'b1);
		issue(CMD_READ, 0, 0, 1'b0);
		issue(CMD_WRITE, 79, 24, 1'b1);
		issue(CMD_READ, 79, 24, 1'b0);
		issue(CMD_WRITE, 79, 24, 1'b0);
		issue(CMD_READ, 79, 24, 1'b1);
		issue(CMD_READ, 80, 0, 1'b0);
		issue(CMD_READ, 0, 25, 1'b0);
		issue(CMD_WRITE, 127, 31, 1'b1);
		issue(CMD_READ, 127, 31, 1'b1);
		issue(CMD_UNKNOWN, 127, 31, 1'b1);

		// tiny grid with the usual thresholds: generations and read-back
		apply_setting(8'd4, 8'd3, 8'd4, 8'd3);
		fill_grid();
		issue(CMD_GEN, 0, 0, 1'b0);
		issue(CMD_READ, 0, 0, 1'b0);
		issue(CMD_READ, 3, 2, 1'b0);
		issue(CMD_WRITE, 3, 0, 1'b1);
		issue(CMD_GEN, 127, 31, 1'b1);
		issue(CMD_READ, 3, 0, 1'b0);
		issue(CMD_READ, 1, 1, 1'b0);
		issue(CMD_WRITE, 4, 0, 1'b1);
		random_items(8);

		// single cell with zero thresholds, a tall column clamped to the row
		// capacity, width clamped with zero height, zero width, mid-size grid
		run_phase(8'd1, 8'd1, 8'd0, 8'd0, 6);
		run_phase(8'd1, 8'd63, 8'd8, 8'd1, 8);
		run_phase(8'd255, 8'd0, 8'd15, 8'd0, 6);
		run_phase(8'd0, 8'd5, 8'd4, 8'd3, 6);
		run_phase(8'd6, 8'd4, 8'd4, 8'd5, 8);

		// random small sizes; spare upper data bits must be ignored
		repeat (2) begin
			run_phase(8'($urandom_range(2, 8)),
				{2'($urandom_range(0, 3)), 6'($urandom_range(2, 6))},
				{4'($urandom_range(0, 15)), 4'($urandom_range(0, 9))},
				{4'($urandom_range(0, 15)), 4'($urandom_range(0, 9))}, 8);
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Covered %0d register settings: %0d writes, %0d reads, %0d generations",
			n_settings, n_write, n_read, n_gen);
		$display("including %0d out-of-range coordinates and %0d unknown commands",
			n_coord_err, n_unknown);
		if (fail_count == 0 && words_pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog: ends a hung run
	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: cave_cellular_automaton_step.f
hdl/cca_pkg.sv
hdl/cca_ram.sv
hdl/cca_window.sv
hdl/cave_cellular_automaton_step.sv
test/cave_step_monitor.sv
test/tb_cave_cellular_automaton_step.sv
